@@ src/dtpc_pkg.sv @@
package dtpc_pkg;
  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned CoordBits = 31;
  localparam int unsigned DistBits = 31;
  localparam int unsigned IdxInBits = 10;
  localparam int unsigned OutBits = 11;
  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic load;        // write point at point count
    logic new_set;     // restart point count / cluster count
    logic clear_run;   // reset head/tail/done/cc/seed ptr
    logic seed_rd;     // issue label read at seed pointer
    logic seed_step;   // seed pointer advance
    logic seed_take;   // label seed, push, cc++
    logic deq;         // pop queue head into k
    logic kx_rd;       // read coords of k
    logic kx_lat;      // latch coords of k
    logic scan_init_l; // j = k (left scan)
    logic scan_init_r; // j = k+1 (right scan)
    logic cand_rd;     // read candidate coords+label
    logic cand_eval;   // evaluate, maybe label+push, advance j
    logic finish;      // store cluster counter
    logic rd_label;    // read label for op 1
  } dtpc_cmd_t;

  typedef struct packed {
    logic queue_empty;
    logic all_done;
    logic seed_end;    // seed ptr reached n
    logic seed_free;   // label at seed ptr is zero
    logic left_end;    // left scan exhausted
    logic right_end;   // right scan exhausted
    logic stop;        // x gap stops scan
    logic scan_left;
  } dtpc_sts_t;
endpackage

@@ src/dtpc_ram.sv @@
module dtpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end
  assign rdata_o = rdata_q;
endmodule

@@ src/dtpc_datapath.sv @@
module dtpc_datapath #(
  parameter int unsigned MaxPoints = dtpc_pkg::MaxPoints,
  parameter int unsigned CoordBits = dtpc_pkg::CoordBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dtpc_pkg::dtpc_cmd_t               cmd_i,
  output dtpc_pkg::dtpc_sts_t               sts_o,
  input  logic [CoordBits-1:0]              x_i,
  input  logic [CoordBits-1:0]              y_i,
  input  logic [dtpc_pkg::IdxInBits-1:0]    read_index_i,
  input  logic [dtpc_pkg::DistBits-1:0]     dist_i,
  output logic [dtpc_pkg::OutBits-1:0]      cluster_count_o,
  output logic [dtpc_pkg::OutBits-1:0]      label_o
);
  localparam int unsigned AW = $clog2(MaxPoints);
  localparam int unsigned CW = $clog2(MaxPoints + 1);
  localparam int unsigned OW = dtpc_pkg::OutBits;
  localparam int unsigned DW = dtpc_pkg::DistBits;
  localparam int unsigned LW = (CW > OW) ? CW : OW;

  logic [CW-1:0] n_q, n_d, head_q, tail_q, done_q, seed_q, j_q;
  logic [LW-1:0] cc_q, cnt_q;
  logic [AW-1:0] k_q;
  logic signed [CoordBits-1:0] kx_q, ky_q;
  logic          scan_left_q;
  logic          lbl_sel_q;  // label read is for read_index in range
  logic          seed_fwd_q; // seed pushed last cycle, queue read still stale

  // memories
  logic [AW-1:0] coord_ra, lbl_ra, lbl_wa, q_ra;
  logic          coord_we, lbl_we, q_we;
  logic [LW-1:0] lbl_wd, lbl_rd;
  logic [CoordBits-1:0] x_rd, y_rd;
  logic [AW-1:0] q_rd;
  logic [AW-1:0] q_ra_n;
  logic          within_w;

  logic [CW-1:0] nb;  // effective count for this load
  assign nb = cmd_i.new_set ? '0 : n_q;

  dtpc_ram #(.Width(CoordBits), .Depth(MaxPoints)) u_x (
    .clk_i, .we_i(coord_we), .waddr_i(nb[AW-1:0]), .wdata_i(x_i),
    .raddr_i(coord_ra), .rdata_o(x_rd));
  dtpc_ram #(.Width(CoordBits), .Depth(MaxPoints)) u_y (
    .clk_i, .we_i(coord_we), .waddr_i(nb[AW-1:0]), .wdata_i(y_i),
    .raddr_i(coord_ra), .rdata_o(y_rd));
  dtpc_ram #(.Width(LW), .Depth(MaxPoints)) u_lbl (
    .clk_i, .we_i(lbl_we), .waddr_i(lbl_wa), .wdata_i(lbl_wd),
    .raddr_i(lbl_ra), .rdata_o(lbl_rd));
  dtpc_ram #(.Width(AW), .Depth(MaxPoints)) u_q (
    .clk_i, .we_i(q_we), .waddr_i(tail_q[AW-1:0]), .wdata_i(q_ra_n),
    .raddr_i(q_ra), .rdata_o(q_rd));

  logic full;
  assign full = (nb == CW'(MaxPoints));
  assign coord_we = cmd_i.load && !full;
  assign n_d = nb;

  // candidate index j-1 (left) or j (right)
  logic [CW-1:0] cand;
  assign cand = scan_left_q ? (j_q - CW'(1)) : j_q;

  always_comb begin
    coord_ra = cand[AW-1:0];
    lbl_ra   = cand[AW-1:0];
    if (cmd_i.kx_rd) coord_ra = k_q;
    if (cmd_i.seed_rd) lbl_ra = seed_q[AW-1:0];
    if (cmd_i.rd_label) lbl_ra = read_index_i[AW-1:0];
  end
  assign q_ra = head_q[AW-1:0];

  // distance: registered coords vs k; squares and radius squared registered
  logic signed [CoordBits:0] dx, dy, gap;
  logic [CoordBits-1:0] adx, ady;
  logic [2*CoordBits-1:0] sqx_q, sqy_q;
  logic [2*CoordBits:0] d2;
  logic [2*DW:0] lim2_q;
  assign dx  = $signed({x_rd[CoordBits-1], x_rd}) - $signed({kx_q[CoordBits-1], kx_q});
  assign dy  = $signed({y_rd[CoordBits-1], y_rd}) - $signed({ky_q[CoordBits-1], ky_q});
  assign adx = dx[CoordBits] ? CoordBits'(-dx) : dx[CoordBits-1:0];
  assign ady = dy[CoordBits] ? CoordBits'(-dy) : dy[CoordBits-1:0];
  assign gap = scan_left_q ? -dx : dx;
  assign d2   = (2*CoordBits+1)'(sqx_q) + (2*CoordBits+1)'(sqy_q);
  assign within_w = ({{(2*DW+1){1'b0}}, d2} <= {{(2*CoordBits+1){1'b0}}, lim2_q});
  assign sts_o.stop = !gap[CoordBits] &&
                      ({{DW{1'b0}}, gap[CoordBits-1:0]} > {{CoordBits{1'b0}}, dist_i});
  logic take;
  assign take = cmd_i.cand_eval && !sts_o.stop && (lbl_rd == '0) && within_w &&
                (tail_q < CW'(MaxPoints));

  always_comb begin
    lbl_we = 1'b0;
    lbl_wa = cand[AW-1:0];
    lbl_wd = cc_q;
    q_we   = 1'b0;
    q_ra_n = cand[AW-1:0];
    if (coord_we) begin
      lbl_we = 1'b1; lbl_wa = nb[AW-1:0]; lbl_wd = '0;
    end else if (cmd_i.seed_take) begin
      lbl_we = 1'b1; lbl_wa = seed_q[AW-1:0]; lbl_wd = cc_q + LW'(1);
      q_we = 1'b1; q_ra_n = seed_q[AW-1:0];
    end else if (take) begin
      lbl_we = 1'b1; q_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0; cnt_q <= '0; cc_q <= '0; head_q <= '0; tail_q <= '0;
      done_q <= '0; seed_q <= '0; j_q <= '0; scan_left_q <= 1'b0;
      lbl_sel_q <= 1'b0; seed_fwd_q <= 1'b0;
    end else begin
      seed_fwd_q <= cmd_i.seed_take;
      if (cmd_i.load) begin
        n_q <= coord_we ? n_d + CW'(1) : n_d;
        if (cmd_i.new_set) cnt_q <= '0;
      end
      if (cmd_i.clear_run) begin
        cc_q <= '0; head_q <= '0; tail_q <= '0; done_q <= '0; seed_q <= '0;
      end
      if (cmd_i.seed_step) seed_q <= seed_q + CW'(1);
      if (cmd_i.seed_take) begin
        cc_q <= cc_q + LW'(1); tail_q <= tail_q + CW'(1); done_q <= done_q + CW'(1);
      end
      if (cmd_i.deq) head_q <= head_q + CW'(1);
      if (cmd_i.scan_init_l) begin
        j_q <= CW'(k_q); scan_left_q <= 1'b1;
      end
      if (cmd_i.scan_init_r) begin
        j_q <= CW'(k_q) + CW'(1); scan_left_q <= 1'b0;
      end
      if (cmd_i.cand_eval) begin
        j_q <= scan_left_q ? j_q - CW'(1) : j_q + CW'(1);
        if (take) begin
          tail_q <= tail_q + CW'(1); done_q <= done_q + CW'(1);
        end
      end
      if (cmd_i.finish) begin
        cnt_q <= cc_q; lbl_sel_q <= 1'b0;
      end
      if (cmd_i.rd_label) lbl_sel_q <= (CW'(read_index_i) < n_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.kx_lat) begin
      kx_q <= x_rd; ky_q <= y_rd;
    end
    if (cmd_i.deq) k_q <= seed_fwd_q ? seed_q[AW-1:0] : q_rd;
    sqx_q  <= (2*CoordBits)'(adx * adx);
    sqy_q  <= (2*CoordBits)'(ady * ady);
    lim2_q <= (2*DW+1)'(dist_i * dist_i);
  end

  assign sts_o.queue_empty = (head_q == tail_q);
  assign sts_o.all_done    = (done_q >= n_q);
  assign sts_o.seed_end    = (seed_q >= n_q);
  assign sts_o.seed_free   = (lbl_rd == '0);
  assign sts_o.left_end    = (j_q == '0);
  assign sts_o.right_end   = (j_q >= n_q);
  assign sts_o.scan_left   = scan_left_q;

  assign cluster_count_o = OW'(cnt_q);
  assign label_o         = lbl_sel_q ? OW'(lbl_rd) : '0;
endmodule

@@ src/dtpc_ctrl.sv @@
module dtpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                op_i,
  input  logic                last_i,
  input  dtpc_pkg::dtpc_sts_t sts_i,
  output dtpc_pkg::dtpc_cmd_t cmd_o,
  output logic                busy_o,
  output logic                done_o,
  output logic                is_label_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SEED_RD, S_SEED_CHK, S_DEQ, S_KRD, S_KLAT,
    S_CRD, S_CEVAL, S_CSQ, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   closed_q, closed_d, busy_q, done_q, done_d, isl_q, isl_d;
  logic   acc;
  assign acc = start_i && !busy_q;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    closed_d = closed_q;
    done_d   = 1'b0;
    isl_d    = 1'b0;
    case (state_q)
      S_IDLE: if (acc) begin
        if (op_i == dtpc_pkg::OpRead) begin
          // label comes out of the memory register in the result cycle
          cmd_o.rd_label = 1'b1; done_d = 1'b1; isl_d = 1'b1;
        end else begin
          cmd_o.load = 1'b1; cmd_o.new_set = closed_q; closed_d = 1'b0;
          if (last_i) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd_o.clear_run = 1'b1;
        state_d = S_DEQ;  // DEQ sees empty queue -> seeding path
      end
      S_DEQ: begin
        if (sts_i.all_done) state_d = S_FIN;
        else if (sts_i.queue_empty) begin
          state_d = S_SEED_RD;
        end else begin
          cmd_o.deq = 1'b1; state_d = S_KRD;
        end
      end
      S_SEED_RD: begin
        cmd_o.seed_rd = 1'b1; state_d = S_SEED_CHK;
      end
      S_SEED_CHK: begin
        if (sts_i.seed_end) state_d = S_FIN;
        else if (sts_i.seed_free) begin
          cmd_o.seed_take = 1'b1; state_d = S_DEQ;
        end else begin
          cmd_o.seed_step = 1'b1; state_d = S_SEED_RD;
        end
      end
      S_KRD: begin
        cmd_o.kx_rd = 1'b1; cmd_o.scan_init_l = 1'b1; state_d = S_KLAT;
      end
      S_KLAT: begin
        cmd_o.kx_lat = 1'b1;
        if (sts_i.left_end) begin
          cmd_o.scan_init_r = 1'b1;
        end
        state_d = S_CRD;
      end
      S_CRD: begin
        if (sts_i.scan_left ? sts_i.left_end : sts_i.right_end) begin
          if (sts_i.scan_left) cmd_o.scan_init_r = 1'b1;
          else state_d = S_DEQ;
        end else begin
          cmd_o.cand_rd = 1'b1; state_d = S_CEVAL;
        end
      end
      S_CEVAL: begin
        if (sts_i.stop) begin
          if (sts_i.scan_left) begin
            cmd_o.scan_init_r = 1'b1; state_d = S_CRD;
          end else state_d = S_DEQ;
        end else begin
          state_d = S_CSQ;  // squares registered this cycle
        end
      end
      S_CSQ: begin
        cmd_o.cand_eval = 1'b1; state_d = S_CRD;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1; closed_d = 1'b1; done_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; closed_q <= 1'b0; busy_q <= 1'b0;
      done_q <= 1'b0; isl_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      closed_q <= closed_d;
      busy_q   <= (state_d != S_IDLE);
      done_q   <= done_d;
      isl_q    <= isl_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign is_label_o = isl_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("result while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> (done_q && !isl_q))
    else $error("completion missing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.seed_take, cmd_o.cand_eval, cmd_o.load}))
    else $error("label write conflict");
endmodule

@@ src/distance_threshold_point_clustering_unit.sv @@
// A load leaves busy low unless it carries last_point; a label read gives its item in the cycle after start.
// A load with last_point runs clustering: a setup step, a coordinate read and latch per dequeued point,
// a candidate read and evaluation per neighbor examined, a scan-end check, and seed-search label probes.
// The result item comes in the cycle after clustering ends; busy is high until then.
// Throughput is set by the single read port of the label and coordinate memories.
// rst_ni clears count, cluster counter, distance and control; point memories need no reset.
module distance_threshold_point_clustering_unit #(
  parameter int unsigned MAX_POINTS = dtpc_pkg::MaxPoints,
  parameter int unsigned COORD_BITS = dtpc_pkg::CoordBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  output logic                               strobe,
  input  logic                               op_i,
  input  logic signed [COORD_BITS-1:0]       x_coord_i,
  input  logic signed [COORD_BITS-1:0]       y_coord_i,
  input  logic                               last_point_i,
  input  logic [dtpc_pkg::IdxInBits-1:0]     read_index_i,
  output logic [dtpc_pkg::OutBits-1:0]       cluster_count_o,
  output logic [dtpc_pkg::OutBits-1:0]       label_o,
  output logic                               is_label_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [1:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  localparam logic [1:0] AddrDist = 2'd0;
  dtpc_pkg::dtpc_cmd_t cmd;
  dtpc_pkg::dtpc_sts_t sts;
  logic [dtpc_pkg::DistBits-1:0] dist_q;

  // config register: distance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dist_q <= '0;
    else if (psel && penable && pwrite && paddr == AddrDist)
      dist_q <= pwdata[dtpc_pkg::DistBits-1:0];
  end
  assign pready = 1'b1;
  assign prdata = (paddr == AddrDist) ? {1'b0, dist_q} : '0;

  dtpc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .op_i, .last_i(last_point_i),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy), .done_o(strobe), .is_label_o);

  dtpc_datapath #(.MaxPoints(MAX_POINTS), .CoordBits(COORD_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .x_i(x_coord_i), .y_i(y_coord_i),
    .read_index_i, .dist_i(dist_q), .cluster_count_o, .label_o);
endmodule

@@ dv/distance_threshold_point_clustering_unit_test.sv @@
module distance_threshold_point_clustering_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;
  localparam logic [30:0] DistMax = 31'h4000_0000;
  localparam logic signed [30:0] CoordMin = -31'sd1073741824;
  localparam logic signed [30:0] CoordMax = 31'sd1073741823;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, strobe;
  logic op_i = dtpc_pkg::OpLoad;
  logic signed [dtpc_pkg::CoordBits-1:0] x_coord_i = '0;
  logic signed [dtpc_pkg::CoordBits-1:0] y_coord_i = '0;
  logic last_point_i = 1'b0;
  logic [dtpc_pkg::IdxInBits-1:0] read_index_i = '0;
  logic [dtpc_pkg::OutBits-1:0] cluster_count_o, label_o;
  logic is_label_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #1 clk_i = ~clk_i;

  distance_threshold_point_clustering_unit u_dut (
    .clk_i, .rst_ni, .start, .busy, .strobe, .op_i, .x_coord_i, .y_coord_i,
    .last_point_i, .read_index_i, .cluster_count_o, .label_o, .is_label_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  typedef struct packed {
    logic [dtpc_pkg::OutBits-1:0] count;
    logic [dtpc_pkg::OutBits-1:0] lab;
    logic                         is_lab;
  } cl_result_t;

  // one directed item; has_exp marks rows whose result is typed in
  typedef struct {
    logic            op;
    int              x;
    int              y;
    logic            last;
    int              idx;
    bit              has_exp;
    cl_result_t      exp;
  } dir_row_t;

  // mirror of the block's state
  longint          xs [dtpc_pkg::MaxPoints];
  longint          ys [dtpc_pkg::MaxPoints];
  int unsigned     labs [dtpc_pkg::MaxPoints];
  int unsigned     vq [dtpc_pkg::MaxPoints];
  int unsigned     npts, nclus;
  bit              closed;
  longint unsigned dist_cfg;

  cl_result_t      pending_q [$];
  int unsigned     n_err, cycles;
  bit              quiet;

  // typed expectation riding along with the item being driven
  bit              cur_has_exp = 1'b0;
  cl_result_t      cur_exp = '0;

  function automatic bit joins(int unsigned a, int unsigned b, longint unsigned lim2);
    longint unsigned dx, dy;
    dx = (xs[a] >= xs[b]) ? xs[a] - xs[b] : xs[b] - xs[a];
    dy = (ys[a] >= ys[b]) ? ys[a] - ys[b] : ys[b] - ys[a];
    return dx * dx + dy * dy <= lim2;
  endfunction

  // breadth-first labeling, scans stop at the first x gap over the radius
  function automatic void cluster_points();
    int unsigned head, tail, done, cc, k, p;
    longint lim;
    longint unsigned lim2;
    head = 0; tail = 0; done = 0; cc = 0;
    lim = longint'(dist_cfg);
    lim2 = dist_cfg * dist_cfg;
    while (done < npts) begin
      if (head == tail) begin
        k = 0;
        while (k < npts && labs[k] != 0) k++;
        if (k >= npts) break;
        cc++;
        labs[k] = cc;
        done++;
        vq[tail++] = k;
      end
      k = vq[head++];
      for (int unsigned j = k; j > 0; j--) begin
        p = j - 1;
        if (xs[k] - xs[p] > lim) break;
        if (labs[p] == 0 && joins(k, p, lim2) && tail < dtpc_pkg::MaxPoints) begin
          labs[p] = cc; done++; vq[tail++] = p;
        end
      end
      for (int unsigned j = k + 1; j < npts; j++) begin
        if (xs[j] - xs[k] > lim) break;
        if (labs[j] == 0 && joins(k, j, lim2) && tail < dtpc_pkg::MaxPoints) begin
          labs[j] = cc; done++; vq[tail++] = j;
        end
      end
    end
    nclus = cc;
  endfunction

  // returns 1 and fills res when the item produces a result
  function automatic bit predict_item(logic op, logic signed [30:0] x, logic signed [30:0] y,
                                      logic last, logic [9:0] idx, output cl_result_t res);
    res = '0;
    if (op == dtpc_pkg::OpRead) begin
      res.count = nclus[dtpc_pkg::OutBits-1:0];
      res.lab = (idx < npts) ? labs[idx][dtpc_pkg::OutBits-1:0] : '0;
      res.is_lab = 1'b1;
      return 1'b1;
    end
    if (closed) begin
      npts = 0; nclus = 0; closed = 1'b0;
    end
    if (npts < dtpc_pkg::MaxPoints) begin
      xs[npts] = longint'(x);
      ys[npts] = longint'(y);
      labs[npts] = 0;
      npts++;
    end
    if (!last) return 1'b0;
    cluster_points();
    closed = 1'b1;
    res.count = nclus[dtpc_pkg::OutBits-1:0];
    return 1'b1;
  endfunction

  // predict on accept, check on strobe; both sample pre-edge values
  always @(posedge clk_i) begin
    cl_result_t want, got;
    if (rst_ni && start && !busy) begin
      if (predict_item(op_i, x_coord_i, y_coord_i, last_point_i, read_index_i, want))
        pending_q.push_back(cur_has_exp ? cur_exp : want);
    end
    if (rst_ni && strobe) begin
      got = '{count: cluster_count_o, lab: label_o, is_lab: is_label_o};
      if (pending_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result item %p", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("distance_threshold_point_clustering_unit regression: fail");
      $finish;
    end
  end

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(logic op, logic signed [30:0] x, logic signed [30:0] y,
                           logic last, logic [9:0] idx, bit has_exp, cl_result_t exp);
    start <= 1'b1;
    op_i <= op; x_coord_i <= x; y_coord_i <= y;
    last_point_i <= last; read_index_i <= idx;
    cur_has_exp <= has_exp; cur_exp <= exp;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    idle_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic set_distance(logic [30:0] d);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {1'b0, d};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    dist_cfg = d;
    @(posedge clk_i);
  endtask

  // one point set with random content, labels read back along the way
  task automatic random_set(int unsigned n, int unsigned span, bit sorted);
    logic signed [30:0] x, y, bx, by;
    bx = $urandom_range(0, 32'h7FFF_FFFF) - 32'sd1073741824;
    by = $urandom_range(0, 32'h7FFF_FFFF) - 32'sd1073741824;
    if (bx > CoordMax - 31'sd2000000) bx = CoordMax - 31'sd2000000;
    x = bx;
    for (int unsigned i = 0; i < n; i++) begin
      if (sorted) x = x + $urandom_range(0, span);
      else x = bx + $urandom_range(0, span * 4);
      y = by + $urandom_range(0, span * 2) - span;
      if ($urandom_range(0, 40) == 0) y = $urandom();
      send_item(dtpc_pkg::OpLoad, x, y, i == n - 1, $urandom(), 1'b0, '0);
      if ($urandom_range(0, 7) == 0)
        send_item(dtpc_pkg::OpRead, $urandom(), $urandom(), $urandom(),
                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, n), 1'b0, '0);
    end
    repeat ($urandom_range(1, 5))
      send_item(dtpc_pkg::OpRead, $urandom(), $urandom(), $urandom(),
                $urandom_range(0, n), 1'b0, '0);
  endtask

  initial begin
    dir_row_t dirs [$];
    npts = 0; nclus = 0; closed = 1'b0; dist_cfg = 0;
    n_err = 0; cycles = 0; quiet = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reads after reset, extreme corners, coincident points
    dirs = '{
      '{dtpc_pkg::OpRead, 0, 0, 0, 0, 1, '{0, 0, 1}},
      '{dtpc_pkg::OpRead, 0, 0, 1, 1023, 1, '{0, 0, 1}},
      '{dtpc_pkg::OpLoad, CoordMin, CoordMin, 0, 0, 1, '{0, 0, 0}},
      '{dtpc_pkg::OpRead, 0, 0, 0, 0, 1, '{0, 0, 1}},     // before clustering reads 0
      '{dtpc_pkg::OpLoad, CoordMax, CoordMax, 0, 0, 1, '{0, 0, 0}},
      '{dtpc_pkg::OpLoad, 0, 0, 1, 0, 1, '{3, 0, 0}},     // unsorted x, no neighbors
      '{dtpc_pkg::OpRead, 0, 0, 0, 0, 1, '{3, 1, 1}},
      '{dtpc_pkg::OpRead, 0, 0, 0, 1, 1, '{3, 2, 1}},
      '{dtpc_pkg::OpRead, 0, 0, 0, 2, 1, '{3, 3, 1}},
      '{dtpc_pkg::OpRead, 0, 0, 0, 3, 1, '{3, 0, 1}},     // beyond count
      '{dtpc_pkg::OpLoad, 5, 5, 0, 0, 1, '{0, 0, 0}},     // new set begins
      '{dtpc_pkg::OpLoad, 5, 5, 1, 0, 1, '{1, 0, 0}},     // zero radius joins equals
      '{dtpc_pkg::OpRead, 0, 0, 0, 1, 1, '{1, 1, 1}},
      '{dtpc_pkg::OpLoad, 7, -9, 1, 0, 1, '{1, 0, 0}},    // one-point set
      '{dtpc_pkg::OpRead, 0, 0, 0, 1, 1, '{1, 0, 1}}
    };
    foreach (dirs[i])
      send_item(dirs[i].op, dirs[i].x, dirs[i].y, dirs[i].last, dirs[i].idx,
                dirs[i].has_exp, dirs[i].exp);

    // radius 2**30 over the full coordinate range
    set_distance(DistMax);
    send_item(dtpc_pkg::OpLoad, CoordMin, 0, 0, 0, 1'b0, '0);
    send_item(dtpc_pkg::OpLoad, CoordMin + 31'sd3, 31'sd4, 0, 0, 1'b0, '0);
    send_item(dtpc_pkg::OpLoad, CoordMax, CoordMax, 1, 0, 1'b0, '0);
    for (int i = 0; i < 4; i++) send_item(dtpc_pkg::OpRead, 0, 0, 0, i, 1'b0, '0);

    // fill the store past capacity; overflowing loads are dropped
    set_distance(31'd15);
    for (int i = 0; i < dtpc_pkg::MaxPoints + 6; i++)
      send_item(dtpc_pkg::OpLoad, 10 * i - 5000, (i % 3) - 1,
                i == dtpc_pkg::MaxPoints + 5, 0, 1'b0, '0);
    send_item(dtpc_pkg::OpRead, 0, 0, 0, 1023, 1'b0, '0);
    send_item(dtpc_pkg::OpRead, 0, 0, 0, 0, 1'b0, '0);

    // random sets under several radii
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_distance(31'd0);
        1: set_distance(31'd40);
        2: set_distance($urandom_range(1, 200));
        3: set_distance(DistMax);
        4: set_distance($urandom());
        default: begin
          set_distance(31'd25);
          quiet = 1'b1;
        end
      endcase
      repeat (7) begin
        random_set($urandom_range(0, 9) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 20),
                   $urandom_range(0, 3) == 0 ? 200 : 30, $urandom_range(0, 5) != 0);
      end
    end

    drain();
    if (n_err == 0)
      $display("distance_threshold_point_clustering_unit regression: pass");
    else
      $display("distance_threshold_point_clustering_unit regression: fail");
    $finish;
  end
endmodule

@@ sim.f @@
src/dtpc_pkg.sv
src/dtpc_ram.sv
src/dtpc_datapath.sv
src/dtpc_ctrl.sv
src/distance_threshold_point_clustering_unit.sv
dv/distance_threshold_point_clustering_unit_test.sv
